### rtl/core/mau_pkg.sv
// Package: types, widths and codes shared by the modular arithmetic unit.
package mau_pkg;

   localparam int OperandWidth = 32;
   localparam int ModWidth     = 31;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int CountWidth   = $clog2(ProdWidth + 1);
   localparam int CoefWidth    = ModWidth + 2;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_WAIT_A,
      ST_RED_B,
      ST_WAIT_B,
      ST_EXEC,
      ST_EU_CHK,
      ST_EU_WAIT,
      ST_EU_MUL,
      ST_EU_UPD,
      ST_INV_FIX,
      ST_INV_WRAP,
      ST_MUL,
      ST_MUL_RED,
      ST_MUL_WAIT,
      ST_DONE
   } state_type;

   // Divider launch controls from the sequencer.
   typedef struct packed {
      logic                    start;
      logic [ProdWidth-1:0]    num;
      logic [ModWidth-1:0]     den;
      logic [CountWidth-1:0]   cnt;
   } div_ctl_type;

endpackage

### rtl/core/modular_arithmetic_unit_core.sv
// Top level: modular add, subtract, multiply and divide with a shared serial divider.
//
//   channel | direction | ports                                   | handshake
//   req     | in        | req_mode, req_left_operand, req_right_operand | req_valid / req_stall
//   rsp     | out       | rsp_residue, rsp_no_inverse             | rsp_valid / rsp_stall
//   csr     | in        | csr_modulus                             | csr_write
//
// One item at a time. Each operand is reduced by a pass of the divider. Multiply adds a
// 64-bit product reduction. Divide runs a divider pass in every Euclid step.
// Reset (synchronous) sets the modulus to 2 and empties the sequencer and output beat.
// req_stall is high from accept until the result loads; a stalled output beat holds the final state.
module modular_arithmetic_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic signed [mau_pkg::OperandWidth-1:0] req_left_operand,
   input  logic signed [mau_pkg::OperandWidth-1:0] req_right_operand,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mau_pkg::ModWidth-1:0]  rsp_residue,
   output logic                          rsp_no_inverse,
   input  logic                          csr_write,
   input  logic [mau_pkg::ModWidth-1:0]  csr_modulus
);

   localparam int OW = mau_pkg::OperandWidth;
   localparam int MW = mau_pkg::ModWidth;
   localparam int PW = mau_pkg::ProdWidth;
   localparam int CW = mau_pkg::CountWidth;
   localparam int SW = mau_pkg::CoefWidth;

   mau_pkg::state_type state_ff, state_in;
   mau_pkg::div_ctl_type div_ctl;

   logic [MW-1:0]        modulus_ff;
   logic [MW-1:0]        m_ff;
   logic [1:0]           mode_ff;
   logic [OW-1:0]        raw_a_ff, raw_b_ff;
   logic [MW-1:0]        a_ff, b_ff;
   logic [MW-1:0]        old_r_ff, r_ff, q_ff;
   logic signed [SW-1:0] old_s_ff, s_ff;
   logic [OW-1:0]        inv_ff;
   logic [PW-1:0]        prod_ff;
   logic [MW-1:0]        res_ff;
   logic                 flag_ff;
   logic                 rsp_valid_ff;
   logic [MW-1:0]        rsp_residue_ff;
   logic                 rsp_no_inverse_ff;
   logic                 load_rsp;

   // divider registers
   logic                 div_busy_ff;
   logic [CW-1:0]        div_cnt_ff;
   logic [PW-1:0]        div_num_ff;
   logic [MW-1:0]        div_den_ff;
   logic [OW-1:0]        div_rem_ff;
   logic [OW-1:0]        div_quo_ff;
   logic [OW-1:0]        div_rem_sh;
   logic                 div_fit;

   logic                 accept;
   logic                 neg_a, neg_b;
   logic [OW-1:0]        mag_a, mag_b;
   logic [MW-1:0]        div_r;
   logic [OW-1:0]        sum;
   logic signed [OW-1:0]   mul_x;
   logic signed [SW:0]     mul_y;
   logic signed [OW+SW:0]  mul_p;
   logic signed [SW-1:0]   inv_v;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != mau_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residue    = rsp_residue_ff;
   assign rsp_no_inverse = rsp_no_inverse_ff;

   // Operand magnitudes; the most negative value wraps to itself as unsigned.
   assign neg_a = raw_a_ff[OW-1];
   assign neg_b = raw_b_ff[OW-1];
   assign mag_a = neg_a ? (~raw_a_ff + 1'b1) : raw_a_ff;
   assign mag_b = neg_b ? (~raw_b_ff + 1'b1) : raw_b_ff;
   assign div_r = div_rem_ff[MW-1:0];

   // Shared adder for add and subtract.
   always_comb begin
      if (mode_ff == mau_pkg::MODE_ADD) begin
         sum = {1'b0, a_ff} + {1'b0, b_ff};
      end else begin
         sum = (a_ff >= b_ff) ? ({1'b0, a_ff} - {1'b0, b_ff})
                              : ({1'b0, a_ff} + {1'b0, m_ff} - {1'b0, b_ff});
      end
   end

   // Shared multiplier: q*s during Euclid, a*b otherwise.
   always_comb begin
      if (state_ff == mau_pkg::ST_EU_MUL) begin
         mul_x = {1'b0, q_ff};
         mul_y = {s_ff[SW-1], s_ff};
      end else begin
         mul_x = {1'b0, a_ff};
         mul_y = {3'b000, b_ff};
      end
      mul_p = mul_x * mul_y;
   end

   assign inv_v = old_s_ff[SW-1] ? (old_s_ff + $signed({2'b00, m_ff})) : old_s_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mau_pkg::ST_IDLE:     if (accept) state_in = mau_pkg::ST_RED_A;
         mau_pkg::ST_RED_A:    state_in = mau_pkg::ST_WAIT_A;
         mau_pkg::ST_WAIT_A:   if (!div_busy_ff) state_in = mau_pkg::ST_RED_B;
         mau_pkg::ST_RED_B:    state_in = mau_pkg::ST_WAIT_B;
         mau_pkg::ST_WAIT_B:   if (!div_busy_ff) state_in = mau_pkg::ST_EXEC;
         mau_pkg::ST_EXEC: begin
            unique case (mode_ff)
               mau_pkg::MODE_ADD: state_in = mau_pkg::ST_DONE;
               mau_pkg::MODE_SUB: state_in = mau_pkg::ST_DONE;
               mau_pkg::MODE_MUL: state_in = mau_pkg::ST_MUL;
               mau_pkg::MODE_DIV: state_in = mau_pkg::ST_EU_CHK;
               default:           state_in = mau_pkg::ST_DONE;
            endcase
         end
         mau_pkg::ST_EU_CHK: begin
            state_in = (r_ff == '0) ? mau_pkg::ST_INV_FIX : mau_pkg::ST_EU_WAIT;
         end
         mau_pkg::ST_EU_WAIT:  if (!div_busy_ff) state_in = mau_pkg::ST_EU_MUL;
         mau_pkg::ST_EU_MUL:   state_in = mau_pkg::ST_EU_UPD;
         mau_pkg::ST_EU_UPD:   state_in = mau_pkg::ST_EU_CHK;
         mau_pkg::ST_INV_FIX: begin
            state_in = (old_r_ff == MW'(1)) ? mau_pkg::ST_INV_WRAP : mau_pkg::ST_DONE;
         end
         mau_pkg::ST_INV_WRAP: state_in = mau_pkg::ST_MUL;
         mau_pkg::ST_MUL:      state_in = mau_pkg::ST_MUL_RED;
         mau_pkg::ST_MUL_RED:  state_in = mau_pkg::ST_MUL_WAIT;
         mau_pkg::ST_MUL_WAIT: if (!div_busy_ff) state_in = mau_pkg::ST_DONE;
         mau_pkg::ST_DONE:     if (load_rsp) state_in = mau_pkg::ST_IDLE;
         default:              state_in = mau_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: divider launches and output load.
   always_comb begin
      div_ctl.start = 1'b0;
      div_ctl.num   = {mag_a, {OW{1'b0}}};
      div_ctl.den   = m_ff;
      div_ctl.cnt   = CW'(OW);
      load_rsp      = (state_ff == mau_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      unique case (state_ff)
         mau_pkg::ST_RED_A: div_ctl.start = 1'b1;
         mau_pkg::ST_RED_B: begin
            div_ctl.start = 1'b1;
            div_ctl.num   = {mag_b, {OW{1'b0}}};
         end
         mau_pkg::ST_EU_CHK: begin
            div_ctl.start = (r_ff != '0);
            div_ctl.num   = {1'b0, old_r_ff, {OW{1'b0}}};
            div_ctl.den   = r_ff;
         end
         mau_pkg::ST_MUL_RED: begin
            div_ctl.start = 1'b1;
            div_ctl.num   = prod_ff;
            div_ctl.cnt   = CW'(PW);
         end
         default: div_ctl.start = 1'b0;
      endcase
   end

   // Serial restoring divider: one quotient bit per cycle.
   assign div_rem_sh = {div_rem_ff[OW-2:0], div_num_ff[PW-1]};
   assign div_fit    = (div_rem_sh >= {1'b0, div_den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (div_ctl.start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= div_ctl.cnt;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (div_cnt_ff == CW'(1)) div_busy_ff <= 1'b0;
      end
      if (div_ctl.start) begin
         div_num_ff <= div_ctl.num;
         div_den_ff <= div_ctl.den;
         div_rem_ff <= '0;
         div_quo_ff <= '0;
      end else if (div_busy_ff) begin
         div_num_ff <= {div_num_ff[PW-2:0], 1'b0};
         div_rem_ff <= div_fit ? (div_rem_sh - {1'b0, div_den_ff}) : div_rem_sh;
         div_quo_ff <= {div_quo_ff[OW-2:0], div_fit};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mau_pkg::ST_IDLE;
         modulus_ff   <= MW'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) modulus_ff <= csr_modulus;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_residue_ff    <= res_ff;
         rsp_no_inverse_ff <= flag_ff;
      end
      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (accept) begin
               mode_ff  <= req_mode;
               raw_a_ff <= req_left_operand;
               raw_b_ff <= req_right_operand;
               m_ff     <= (modulus_ff == '0) ? MW'(1) : modulus_ff;
               flag_ff  <= 1'b0;
            end
         end
         mau_pkg::ST_WAIT_A: begin
            if (!div_busy_ff)
               a_ff <= (neg_a && div_r != '0) ? (m_ff - div_r) : div_r;
         end
         mau_pkg::ST_WAIT_B: begin
            if (!div_busy_ff)
               b_ff <= (neg_b && div_r != '0) ? (m_ff - div_r) : div_r;
         end
         mau_pkg::ST_EXEC: begin
            res_ff   <= (sum >= {1'b0, m_ff}) ? MW'(sum - {1'b0, m_ff}) : sum[MW-1:0];
            old_r_ff <= b_ff;
            r_ff     <= m_ff;
            old_s_ff <= SW'(1);
            s_ff     <= '0;
         end
         mau_pkg::ST_EU_WAIT: begin
            if (!div_busy_ff) begin
               q_ff     <= div_quo_ff[MW-1:0];
               old_r_ff <= r_ff;
               r_ff     <= div_r;
            end
         end
         mau_pkg::ST_EU_MUL: prod_ff <= mul_p[PW-1:0];
         mau_pkg::ST_EU_UPD: begin
            old_s_ff <= s_ff;
            s_ff     <= old_s_ff - $signed(prod_ff[SW-1:0]);
         end
         mau_pkg::ST_INV_FIX: begin
            inv_ff <= inv_v[OW-1:0];
            if (old_r_ff != MW'(1)) begin
               flag_ff <= 1'b1;
               res_ff  <= '0;
            end
         end
         mau_pkg::ST_INV_WRAP: begin
            b_ff <= (inv_ff >= {1'b0, m_ff}) ? MW'(inv_ff - {1'b0, m_ff}) : inv_ff[MW-1:0];
         end
         mau_pkg::ST_MUL: prod_ff <= mul_p[PW-1:0];
         mau_pkg::ST_MUL_WAIT: if (!div_busy_ff) res_ff <= div_r;
         default: ;
      endcase
   end

`ifndef SYNTH
   // Divider runs only while the sequencer waits on it.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (state_ff == mau_pkg::ST_WAIT_A || state_ff == mau_pkg::ST_WAIT_B ||
                       state_ff == mau_pkg::ST_EU_WAIT || state_ff == mau_pkg::ST_MUL_WAIT))
      else $error("divider busy outside a wait state");

   // Output residue is always reduced.
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_residue < m_ff)
      else $error("residue not below modulus");

   // No-inverse flag only in divide mode.
   a_flag_mode: assert property (@(posedge clock) disable iff (reset)
      load_rsp && flag_ff |-> mode_ff == mau_pkg::MODE_DIV)
      else $error("no_inverse outside divide");

   // An accepted beat leaves idle.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == mau_pkg::ST_RED_A)
      else $error("accept did not start sequence");
`endif

endmodule

### bench/tb_modular_arithmetic_unit_core.sv
// Testbench for the modular arithmetic unit: directed and random beats, locally predicted.
`timescale 1ns / 1ps

module tb_modular_arithmetic_unit_core;

   typedef struct {
      logic [mau_pkg::ModWidth-1:0] residue;
      logic                         no_inverse;
   } residue_beat_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_mode;
   logic signed [mau_pkg::OperandWidth-1:0] req_left_operand;
   logic signed [mau_pkg::OperandWidth-1:0] req_right_operand;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [mau_pkg::ModWidth-1:0]  rsp_residue;
   logic                          rsp_no_inverse;
   logic                          csr_write;
   logic [mau_pkg::ModWidth-1:0]  csr_modulus;

   residue_beat_type residue_q[$];
   logic [mau_pkg::ModWidth-1:0] modulus_now;
   int mismatches;
   bit idling_on;

   modular_arithmetic_unit_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_left_operand  (req_left_operand),
      .req_right_operand (req_right_operand),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_residue       (rsp_residue),
      .rsp_no_inverse    (rsp_no_inverse),
      .csr_write         (csr_write),
      .csr_modulus       (csr_modulus)
   );

   // Free-running clock, 12 ns period.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Fold a two's complement operand into 0..m-1.
   function automatic longint unsigned fold_operand(
         logic [mau_pkg::OperandWidth-1:0] raw, longint unsigned m);
      logic [mau_pkg::OperandWidth-1:0] mag;
      longint unsigned rem;
      if (!raw[mau_pkg::OperandWidth-1])
         return longint'(raw) % m;
      mag = -raw;
      rem = {32'b0, mag} % m;
      return (rem == 0) ? 0 : m - rem;
   endfunction

   // Compute the expected residue and no-inverse flag of one beat.
   function automatic residue_beat_type mod_result(logic [1:0] mode,
         logic [mau_pkg::OperandWidth-1:0] a_raw,
         logic [mau_pkg::OperandWidth-1:0] b_raw,
         logic [mau_pkg::ModWidth-1:0] m_reg);
      residue_beat_type beat;
      longint unsigned m, a, b, res;
      longint old_r, r, old_s, s, q, t;
      m = (m_reg == 0) ? 1 : longint'(m_reg);
      a = fold_operand(a_raw, m);
      b = fold_operand(b_raw, m);
      res = 0;
      beat.no_inverse = 1'b0;
      case (mode)
         mau_pkg::MODE_ADD: res = (a + b) % m;
         mau_pkg::MODE_SUB: res = (a + m - b) % m;
         mau_pkg::MODE_MUL: res = (a * b) % m;
         default: begin
            old_r = b;
            r = m;
            old_s = 1;
            s = 0;
            while (r != 0) begin
               q = old_r / r;
               t = old_r - q * r;
               old_r = r;
               r = t;
               t = old_s - q * s;
               old_s = s;
               s = t;
            end
            if (old_r != 1) begin
               beat.no_inverse = 1'b1;
            end else begin
               if (old_s < 0) old_s = old_s + longint'(m);
               res = (a * (unsigned'(old_s) % m)) % m;
            end
         end
      endcase
      beat.residue = res[mau_pkg::ModWidth-1:0];
      return beat;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Record the expectation of each accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         residue_q.push_back(mod_result(req_mode, req_left_operand, req_right_operand,
                                        modulus_now));
   end

   // Check each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      residue_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (residue_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result beat residue=%0d no_inverse=%0b",
                        rsp_residue, rsp_no_inverse);
         end else begin
            want = residue_q.pop_front();
            if (want.residue !== rsp_residue || want.no_inverse !== rsp_no_inverse) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: residue exp %0d got %0d, no_inverse exp %0b got %0b",
                           want.residue, rsp_residue, want.no_inverse, rsp_no_inverse);
            end
         end
      end
   end

   // Stall the result channel in random bursts.
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
      end
   end

   // Send one request beat, holding it until accepted.
   task automatic send_beat(logic [1:0] mode, logic [31:0] a, logic [31:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_mode          = mode;
      req_left_operand  = a;
      req_right_operand = b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Write the modulus once every outstanding beat has drained.
   task automatic set_modulus(logic [mau_pkg::ModWidth-1:0] m);
      wait (residue_q.size() == 0);
      repeat (10) @(negedge clock);
      csr_write   = 1'b1;
      csr_modulus = m;
      modulus_now = m;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [31:0] pick_operand(logic [mau_pkg::ModWidth-1:0] m);
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 20) - 10;
         3: return m * $urandom_range(0, 3);
         4: return -(m * $urandom_range(1, 3));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [mau_pkg::ModWidth-1:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return 31'($urandom_range(2, 16));
         1: return 31'h7fff_ffff;
         2: return 31'($urandom_range(17, 5000));
         3: return 31'd1_000_000_007;
         default: return 31'($urandom);
      endcase
   endfunction

   // Operand extremes and every mode under the reset modulus.
   task automatic test_reset_modulus();
      send_beat(mau_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(mau_pkg::MODE_SUB, 32'h0000_0000, 32'hffff_ffff);
      send_beat(mau_pkg::MODE_MUL, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(mau_pkg::MODE_DIV, 32'd5, 32'd3);
      send_beat(mau_pkg::MODE_DIV, 32'd5, 32'd4);
   endtask

   // Largest modulus, negative operands and a divisor of zero.
   task automatic test_large_modulus();
      set_modulus(31'h7fff_ffff);
      send_beat(mau_pkg::MODE_ADD, 32'h7fff_fffe, 32'h7fff_ffff);
      send_beat(mau_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(mau_pkg::MODE_MUL, 32'h7fff_fffe, 32'h7fff_fffe);
      send_beat(mau_pkg::MODE_MUL, 32'h8000_0000, 32'hffff_ffff);
      send_beat(mau_pkg::MODE_DIV, 32'hffff_ffff, 32'h7fff_fffe);
      send_beat(mau_pkg::MODE_DIV, 32'd7, 32'h7fff_ffff);
      send_beat(mau_pkg::MODE_DIV, 32'h8000_0000, 32'h8000_0001);
   endtask

   // Moduli below two and a composite modulus with no-inverse divisors.
   task automatic test_degenerate_modulus();
      set_modulus(31'd0);
      send_beat(mau_pkg::MODE_ADD, 32'd9, 32'd4);
      send_beat(mau_pkg::MODE_DIV, 32'd9, 32'd0);
      set_modulus(31'd1);
      send_beat(mau_pkg::MODE_MUL, 32'hffff_fff0, 32'd3);
      send_beat(mau_pkg::MODE_DIV, 32'd9, 32'd4);
      set_modulus(31'd12);
      send_beat(mau_pkg::MODE_DIV, 32'd5, 32'd6);
      send_beat(mau_pkg::MODE_DIV, 32'hffff_fffb, 32'hffff_fff9);
      send_beat(mau_pkg::MODE_DIV, 32'd5, 32'd24);
      send_beat(mau_pkg::MODE_SUB, 32'd3, 32'hffff_fff4);
   endtask

   // Random beats over a series of random moduli.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 14; phase++) begin
         logic [mau_pkg::ModWidth-1:0] m;
         m = pick_modulus();
         set_modulus(m);
         idling_on = (phase % 4 != 3);
         for (int i = 0; i < 75; i++)
            send_beat(2'($urandom_range(0, 3)), pick_operand(m), pick_operand(m));
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = mau_pkg::MODE_ADD;
      req_left_operand  = '0;
      req_right_operand = '0;
      csr_write         = 1'b0;
      csr_modulus       = '0;
      modulus_now       = 31'd2;
      mismatches        = 0;
      idling_on         = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_modulus();
      test_large_modulus();
      test_degenerate_modulus();
      test_random_traffic();

      // Drain, then keep running for a while to catch stray beats.
      wait (residue_q.size() == 0);
      repeat (500) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Give up after a generous fixed time.
   initial begin
      #200ms;
      $display("Verification failed");
      $finish;
   end

endmodule

### modular_arithmetic_unit_core.f
rtl/core/mau_pkg.sv
rtl/core/modular_arithmetic_unit_core.sv
bench/tb_modular_arithmetic_unit_core.sv
